// ===== hdl/mags_pkg.sv =====
package mags_pkg;

    localparam int GRID_MAX = 64;
    localparam int MAX_ANTS = 8;
    localparam int COORD_W  = 6;
    localparam int ANT_W    = 3;
    localparam int SIZE_W   = 7;
    localparam int MOD_W    = 8;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PLACE = 2'd2;

    localparam logic [1:0] HEAD_LEFT  = 2'd0;
    localparam logic [1:0] HEAD_RIGHT = 2'd1;
    localparam logic [1:0] HEAD_UP    = 2'd2;
    localparam logic [1:0] HEAD_DOWN  = 2'd3;

    localparam logic CFG_GRID_SIZE = 1'b0;
    localparam logic CFG_ANT_COUNT = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [MOD_W-1:0]     value;
        logic [SIZE_W-1:0]    size;
    } t_mod_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [COORD_W-1:0]   result;
    } t_mod_rsp;

    function automatic logic [1:0] turn_right(input logic [1:0] h);
        logic [1:0] r;
        case (h)
            HEAD_LEFT:  r = HEAD_UP;
            HEAD_RIGHT: r = HEAD_DOWN;
            HEAD_UP:    r = HEAD_RIGHT;
            default:    r = HEAD_LEFT;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] turn_left(input logic [1:0] h);
        logic [1:0] r;
        case (h)
            HEAD_LEFT:  r = HEAD_DOWN;
            HEAD_RIGHT: r = HEAD_UP;
            HEAD_UP:    r = HEAD_LEFT;
            default:    r = HEAD_RIGHT;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/mags_grid_ram.sv =====
module mags_grid_ram import mags_pkg::*; (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [COORD_W-1:0]  i_wr_addr,
    input  logic [GRID_MAX-1:0] i_wr_data,
    input  logic [COORD_W-1:0]  i_rd_addr,
    output logic [GRID_MAX-1:0] o_rd_data
);

    logic [GRID_MAX-1:0] r_mem [0:GRID_MAX-1];
    logic [GRID_MAX-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/mags_mod_unit.sv =====
module mags_mod_unit import mags_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic [MOD_W-1:0]  r_rem;
    logic [SIZE_W-1:0] r_size;
    logic [2:0]        r_k;
    logic              r_busy;
    logic              r_done;
    logic [12:0]       sub;
    logic              take;

    // one restoring step per cycle, divisor shifted down from 64x to 1x
    assign sub  = 13'(r_size) << r_k;
    assign take = (13'(r_rem) >= sub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_rem  <= i_req.value;
                r_size <= i_req.size;
                r_k    <= 3'(COORD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (take) begin
                    r_rem <= r_rem - sub[MOD_W-1:0];
                end
                if (r_k == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 3'd1;
                end
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_rem[COORD_W-1:0];

endmodule

// ===== hdl/multi_ant_grid_stepper.sv =====
// Turmite-style ant walker with up to eight ants on a square torus of 1-bit cells
// held as 64 rows of 64 bits. After reset the block clears the grid one row a
// cycle and accepts no word until all 64 rows are cleared; configuration writes
// are taken throughout. A cell write reads its row when accepted and writes it
// back in S_LOAD_WR; an ant placement is done in the accepting cycle. A tick
// takes each active ant in turn, a row read in S_ANT_RD, then row write and
// result in S_RMW, while every ant stands inside the current grid; the
// read-modify-write on the grid memory paces the ants. An ant left outside a
// shrunk grid instead runs both coordinates, one after the other, through the
// shared modulo unit. The block takes no new word until the tick ends, and a
// result waiting on the output stalls the next ant.
module multi_ant_grid_stepper import mags_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // cell_x, cell_y, cell_value, ant_select, heading_in, zero pad
    input  logic [23:0] i_s_axis_tdata,
    // operation
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // ant_number, flipped_x, flipped_y, flipped_value, ant_x, ant_y, heading_out, zero pad
    output logic [31:0] o_m_axis_tdata,
    // last
    output logic        o_m_axis_tlast
);

    typedef struct packed {
        logic [ANT_W-1:0]   ant;
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic               fv;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [1:0]         hd;
        logic               last;
    } t_result;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_LOAD_WR = 4'd2;
    localparam logic [3:0] S_ANT_RD  = 4'd3;
    localparam logic [3:0] S_RMW     = 4'd4;
    localparam logic [3:0] S_MOD_A   = 4'd5;
    localparam logic [3:0] S_MOD_B   = 4'd6;
    localparam logic [3:0] S_EMIT    = 4'd7;

    logic [3:0]         r_state, n_state;
    logic [COORD_W-1:0] r_clr_cnt;
    logic [SIZE_W-1:0]  r_grid_size;
    logic [3:0]         r_ant_count;
    logic [COORD_W-1:0] r_ant_x [0:MAX_ANTS-1];
    logic [COORD_W-1:0] r_ant_y [0:MAX_ANTS-1];
    logic [1:0]         r_ant_h [0:MAX_ANTS-1];
    logic [ANT_W-1:0]   r_ant;
    logic [COORD_W-1:0] r_lx, r_ly;
    logic               r_lv;
    logic               r_mov_y;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    logic [SIZE_W-1:0]  eff_size;
    logic [3:0]         eff_ants;
    logic [1:0]         in_op;
    logic [COORD_W-1:0] in_x, in_y;
    logic               in_v;
    logic [ANT_W-1:0]   in_sel;
    logic [1:0]         in_h;
    logic               in_acc, in_range, out_free;

    logic [COORD_W-1:0]  cur_x, cur_y;
    logic [1:0]          cur_h;
    logic [GRID_MAX-1:0] rd_data;
    logic                cell_old, new_v, mov_y, mov_plus, fast, is_last;
    logic [1:0]          new_h;
    logic [COORD_W-1:0]  c_mov, c_oth, fast_mov;
    t_result             res_rmw, emit_res;
    logic                emit_now;

    logic                grid_we;
    logic [COORD_W-1:0]  grid_waddr, grid_raddr;
    logic [GRID_MAX-1:0] grid_wdata;

    t_mod_req mod_req;
    t_mod_rsp mod_rsp;

    always_comb begin
        if (r_grid_size < 7'd2) begin
            eff_size = 7'd2;
        end else if (r_grid_size > 7'(GRID_MAX)) begin
            eff_size = 7'(GRID_MAX);
        end else begin
            eff_size = r_grid_size;
        end
    end

    assign eff_ants = (r_ant_count > 4'(MAX_ANTS)) ? 4'(MAX_ANTS) : r_ant_count;

    assign in_op    = i_s_axis_tuser;
    assign in_x     = i_s_axis_tdata[5:0];
    assign in_y     = i_s_axis_tdata[11:6];
    assign in_v     = i_s_axis_tdata[12];
    assign in_sel   = i_s_axis_tdata[15:13];
    assign in_h     = i_s_axis_tdata[17:16];
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign in_range = ({1'b0, in_x} < eff_size) && ({1'b0, in_y} < eff_size);
    assign out_free = !r_out_valid || i_m_axis_tready;

    assign cur_x    = r_ant_x[r_ant];
    assign cur_y    = r_ant_y[r_ant];
    assign cur_h    = r_ant_h[r_ant];
    assign cell_old = rd_data[cur_x];
    assign new_v    = !cell_old;
    assign new_h    = cell_old ? turn_right(cur_h) : turn_left(cur_h);
    assign mov_y    = (new_h == HEAD_UP) || (new_h == HEAD_DOWN);
    assign mov_plus = (new_h == HEAD_RIGHT) || (new_h == HEAD_DOWN);
    assign c_mov    = mov_y ? cur_y : cur_x;
    assign c_oth    = mov_y ? cur_x : cur_y;
    assign fast     = ({1'b0, c_mov} < eff_size) && ({1'b0, c_oth} < eff_size);
    assign is_last  = (({1'b0, r_ant} + 4'd1) == eff_ants);

    always_comb begin
        if (mov_plus) begin
            fast_mov = (({1'b0, c_mov} + 7'd1) == eff_size) ? '0 : c_mov + 6'd1;
        end else begin
            fast_mov = (c_mov == '0) ? 6'(eff_size - 7'd1) : c_mov - 6'd1;
        end
    end

    always_comb begin
        res_rmw.ant  = r_ant;
        res_rmw.fx   = cur_x;
        res_rmw.fy   = cur_y;
        res_rmw.fv   = new_v;
        res_rmw.ax   = mov_y ? cur_x : fast_mov;
        res_rmw.ay   = mov_y ? fast_mov : cur_y;
        res_rmw.hd   = new_h;
        res_rmw.last = is_last;
    end

    assign emit_now = ((r_state == S_RMW) && fast && out_free) ||
                      ((r_state == S_EMIT) && out_free);
    assign emit_res = (r_state == S_EMIT) ? r_res : res_rmw;

    always_comb begin
        mod_req.size  = eff_size;
        mod_req.start = ((r_state == S_RMW) && !fast) ||
                        ((r_state == S_MOD_A) && mod_rsp.done);
        if (r_state == S_RMW) begin
            if (mov_plus) begin
                mod_req.value = 8'(c_mov) + 8'(eff_size) + 8'd1;
            end else begin
                mod_req.value = 8'(c_mov) + 8'(eff_size) - 8'd1;
            end
        end else begin
            mod_req.value = 8'(r_mov_y ? r_res.fx : r_res.fy);
        end
    end

    mags_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    always_comb begin
        grid_we    = 1'b0;
        grid_waddr = cur_y;
        grid_wdata = rd_data;
        case (r_state)
            S_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = r_clr_cnt;
                grid_wdata = '0;
            end
            S_LOAD_WR: begin
                grid_we          = 1'b1;
                grid_waddr       = r_ly;
                grid_wdata[r_lx] = r_lv;
            end
            S_RMW: begin
                grid_we           = 1'b1;
                grid_wdata[cur_x] = new_v;
            end
            default: begin
                grid_we = 1'b0;
            end
        endcase
    end

    assign grid_raddr = (r_state == S_IDLE) ? in_y : cur_y;

    mags_grid_ram u_grid (
        .i_clk     (i_clk),
        .i_we      (grid_we),
        .i_wr_addr (grid_waddr),
        .i_wr_data (grid_wdata),
        .i_rd_addr (grid_raddr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == 6'(GRID_MAX - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if ((in_op == OP_TICK) && (eff_ants != 4'd0)) begin
                        n_state = S_ANT_RD;
                    end else if ((in_op == OP_WRITE) && in_range) begin
                        n_state = S_LOAD_WR;
                    end
                end
            end
            S_LOAD_WR: n_state = S_IDLE;
            S_ANT_RD:  n_state = S_RMW;
            S_RMW: begin
                if (!fast) begin
                    n_state = S_MOD_A;
                end else if (out_free) begin
                    n_state = is_last ? S_IDLE : S_ANT_RD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_MOD_A: begin
                if (mod_rsp.done) begin
                    n_state = S_MOD_B;
                end
            end
            S_MOD_B: begin
                if (mod_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = r_res.last ? S_IDLE : S_ANT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_grid_size <= 7'(GRID_MAX);
            r_ant_count <= 4'd1;
            r_ant       <= '0;
            r_out_valid <= 1'b0;
            r_ant_x     <= '{default: '0};
            r_ant_y     <= '{default: '0};
            r_ant_h     <= '{default: HEAD_LEFT};
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_GRID_SIZE) begin
                    r_grid_size <= i_cfg_data;
                end else begin
                    r_ant_count <= i_cfg_data[3:0];
                end
            end
            case (r_state)
                S_CLEAR: r_clr_cnt <= r_clr_cnt + 6'd1;
                S_IDLE: begin
                    if (in_acc) begin
                        if ((in_op == OP_PLACE) && in_range) begin
                            r_ant_x[in_sel] <= in_x;
                            r_ant_y[in_sel] <= in_y;
                            r_ant_h[in_sel] <= in_h;
                        end
                        r_lx  <= in_x;
                        r_ly  <= in_y;
                        r_lv  <= in_v;
                        r_ant <= '0;
                    end
                end
                S_RMW: begin
                    r_res   <= res_rmw;
                    r_mov_y <= mov_y;
                end
                S_MOD_A: begin
                    if (mod_rsp.done) begin
                        if (r_mov_y) begin
                            r_res.ay <= mod_rsp.result;
                        end else begin
                            r_res.ax <= mod_rsp.result;
                        end
                    end
                end
                S_MOD_B: begin
                    if (mod_rsp.done) begin
                        if (r_mov_y) begin
                            r_res.ax <= mod_rsp.result;
                        end else begin
                            r_res.ay <= mod_rsp.result;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (emit_now) begin
                r_ant_x[r_ant] <= emit_res.ax;
                r_ant_y[r_ant] <= emit_res.ay;
                r_ant_h[r_ant] <= emit_res.hd;
                r_ant          <= r_ant + 3'd1;
                r_out          <= emit_res;
                r_out_valid    <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.hd, r_out.ay, r_out.ax, r_out.fv,
                              r_out.fy, r_out.fx, r_out.ant};
    assign o_m_axis_tlast  = r_out.last;

`ifndef SYNTHESIS
    a_mod_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_req.start |-> !mod_rsp.busy)
        else $error("modulo unit started while busy");

    a_out_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (({1'b0, r_out.ax} < eff_size) && ({1'b0, r_out.ay} < eff_size)))
        else $error("reported ant position outside grid");

    a_ant_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ANT_RD) || (r_state == S_RMW) || (r_state == S_EMIT)) |->
        ({1'b0, r_ant} < eff_ants))
        else $error("ant index beyond active count");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_op == OP_TICK) && (eff_ants != 4'd0)) |=> (r_state == S_ANT_RD))
        else $error("tick did not start with a row read");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mags_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 32;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               v;
        logic [ANT_W-1:0]   sel;
        logic [1:0]         dir;
    } t_load_word;

    typedef struct packed {
        logic [ANT_W-1:0]   ant;
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic               fv;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [1:0]         dir;
        logic               last;
    } t_ant_move;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_GRID_SIZE;
    logic [6:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_data = '0;
    logic [1:0]  s_user = OP_TICK;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic        m_last;

    // model state
    logic [GRID_MAX-1:0] grid_rows [GRID_MAX] = '{default: '0};
    logic [COORD_W-1:0]  ant_col [MAX_ANTS] = '{default: '0};
    logic [COORD_W-1:0]  ant_row [MAX_ANTS] = '{default: '0};
    logic [1:0]          ant_dir [MAX_ANTS] = '{default: HEAD_LEFT};
    logic [SIZE_W-1:0]   cfg_grid = 7'd64;
    logic [3:0]          cfg_ants = 4'd1;

    t_load_word pending_words [$];
    t_ant_move  expected_moves [$];
    t_load_word held_word;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int error_count = 0;
    int stall_cycles = 0;
    int rx_hold_left = 0;
    logic hold_req = 1'b0;

    multi_ant_grid_stepper i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int grid_side();
        if (cfg_grid < 7'd2) return 2;
        if (int'(cfg_grid) > GRID_MAX) return GRID_MAX;
        return int'(cfg_grid);
    endfunction

    function automatic int active_ants();
        if (int'(cfg_ants) > MAX_ANTS) return MAX_ANTS;
        return int'(cfg_ants);
    endfunction

    function automatic string move_text(input t_ant_move m);
        return $sformatf("ant %0d flip (%0d,%0d)=%0d pos (%0d,%0d) dir %0d last %0d",
                         m.ant, m.fx, m.fy, m.fv, m.ax, m.ay, m.dir, m.last);
    endfunction

    task automatic apply_word(input t_load_word w);
        int side;
        int n;
        logic [ANT_W-1:0] a;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        int nx;
        int ny;
        logic [1:0] d;
        logic nv;
        t_ant_move mv;
        side = grid_side();
        n = active_ants();
        case (w.op)
            OP_WRITE: begin
                if (int'(w.x) < side && int'(w.y) < side) grid_rows[w.y][w.x] = w.v;
            end
            OP_PLACE: begin
                if (int'(w.x) < side && int'(w.y) < side) begin
                    ant_col[w.sel] = w.x;
                    ant_row[w.sel] = w.y;
                    ant_dir[w.sel] = w.dir;
                end
            end
            OP_TICK: begin
                for (int i = 0; i < n; i++) begin
                    a = ANT_W'(i);
                    cx = ant_col[a];
                    cy = ant_row[a];
                    d = ant_dir[a];
                    if (grid_rows[cy][cx]) begin
                        nv = 1'b0;
                        case (d)
                            HEAD_LEFT:  d = HEAD_UP;
                            HEAD_RIGHT: d = HEAD_DOWN;
                            HEAD_UP:    d = HEAD_RIGHT;
                            default:    d = HEAD_LEFT;
                        endcase
                    end else begin
                        nv = 1'b1;
                        case (d)
                            HEAD_LEFT:  d = HEAD_DOWN;
                            HEAD_RIGHT: d = HEAD_UP;
                            HEAD_UP:    d = HEAD_LEFT;
                            default:    d = HEAD_RIGHT;
                        endcase
                    end
                    grid_rows[cy][cx] = nv;
                    nx = int'(cx);
                    ny = int'(cy);
                    case (d)
                        HEAD_LEFT:  nx = (int'(cx) + side - 1) % side;
                        HEAD_RIGHT: nx = (int'(cx) + 1) % side;
                        HEAD_UP:    ny = (int'(cy) + side - 1) % side;
                        default:    ny = (int'(cy) + 1) % side;
                    endcase
                    // an ant left outside a shrunk grid is folded back in
                    nx = nx % side;
                    ny = ny % side;
                    ant_col[a] = COORD_W'(nx);
                    ant_row[a] = COORD_W'(ny);
                    ant_dir[a] = d;
                    mv.ant = a;
                    mv.fx = cx;
                    mv.fy = cy;
                    mv.fv = nv;
                    mv.ax = COORD_W'(nx);
                    mv.ay = COORD_W'(ny);
                    mv.dir = d;
                    mv.last = (i == n - 1);
                    expected_moves.push_back(mv);
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) apply_word(held_word);
            if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                held_word = pending_words.pop_front();
                s_user <= held_word.op;
                s_data <= {6'b0, held_word.dir, held_word.sel, held_word.v,
                           held_word.y, held_word.x};
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin : monitor
        t_ant_move got;
        t_ant_move want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.ant = m_data[2:0];
                got.fx = m_data[8:3];
                got.fy = m_data[14:9];
                got.fv = m_data[15];
                got.ax = m_data[21:16];
                got.ay = m_data[27:22];
                got.dir = m_data[29:28];
                got.last = m_last;
                if (expected_moves.size() == 0) begin
                    error_count <= error_count + 1;
                    if (error_count < MAX_REPORTS)
                        $display("unexpected word: %s", move_text(got));
                end else begin
                    want = expected_moves.pop_front();
                    if (got !== want) begin
                        error_count <= error_count + 1;
                        if (error_count < MAX_REPORTS)
                            $display("mismatch: expected %s, got %s",
                                     move_text(want), move_text(got));
                    end
                end
            end
            m_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (hold_req) begin
            rx_hold_left <= HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_word(input logic [1:0] op, input int x, input int y,
                              input logic v, input int sel, input logic [1:0] dir);
        t_load_word w;
        w.op = op;
        w.x = COORD_W'(x);
        w.y = COORD_W'(y);
        w.v = v;
        w.sel = ANT_W'(sel);
        w.dir = dir;
        pending_words.push_back(w);
    endtask

    task automatic queue_random_word();
        t_load_word w;
        int side;
        int pick;
        side = grid_side();
        pick = $urandom_range(99);
        if (pick < 50) w.op = OP_TICK;
        else if (pick < 70) w.op = OP_WRITE;
        else if (pick < 93) w.op = OP_PLACE;
        else w.op = OP_NONE;
        if ($urandom_range(99) < 80) begin
            w.x = COORD_W'($urandom_range(side - 1));
            w.y = COORD_W'($urandom_range(side - 1));
        end else begin
            w.x = COORD_W'($urandom);
            w.y = COORD_W'($urandom);
        end
        w.v = 1'($urandom);
        w.sel = ANT_W'($urandom);
        w.dir = 2'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic set_registers(input logic [6:0] side_val, input logic [6:0] ants_val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_GRID_SIZE;
        cfg_data <= side_val;
        cfg_grid = side_val;
        @(posedge clk);
        cfg_index <= CFG_ANT_COUNT;
        cfg_data <= ants_val;
        cfg_ants = ants_val[3:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic finish_phase();
        do @(negedge clk);
        while (pending_words.size() != 0 || s_valid || expected_moves.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 6;
        rx_idle_pct = 58;

        queue_word(OP_TICK, 0, 0, 1'b0, 0, HEAD_LEFT);
        queue_word(OP_WRITE, 63, 63, 1'b1, 0, HEAD_LEFT);
        queue_word(OP_PLACE, 63, 63, 1'b0, 0, HEAD_RIGHT);
        queue_word(OP_TICK, 0, 0, 1'b0, 0, HEAD_LEFT);
        queue_word(OP_PLACE, 0, 0, 1'b0, 0, HEAD_UP);
        queue_word(OP_TICK, 0, 0, 1'b0, 0, HEAD_LEFT);
        queue_word(OP_TICK, 0, 0, 1'b0, 0, HEAD_LEFT);
        queue_word(OP_PLACE, 10, 20, 1'b1, 0, HEAD_DOWN);
        queue_word(OP_TICK, 0, 0, 1'b0, 0, HEAD_LEFT);
        queue_word(OP_TICK, 0, 0, 1'b0, 0, HEAD_LEFT);
        queue_word(OP_WRITE, 5, 5, 1'b0, 0, HEAD_LEFT);
        queue_word(OP_WRITE, 0, 63, 1'b1, 7, HEAD_DOWN);
        queue_word(OP_NONE, 63, 63, 1'b1, 7, HEAD_DOWN);
        queue_word(OP_PLACE, 63, 0, 1'b0, 7, HEAD_LEFT);
        queue_word(OP_PLACE, 32, 32, 1'b0, 5, HEAD_DOWN);
        queue_word(OP_PLACE, 0, 63, 1'b0, 0, HEAD_LEFT);
        queue_word(OP_TICK, 0, 0, 1'b0, 0, HEAD_LEFT);
        queue_word(OP_TICK, 63, 63, 1'b1, 7, HEAD_DOWN);
        queue_word(OP_TICK, 0, 0, 1'b0, 0, HEAD_LEFT);
        queue_word(OP_TICK, 0, 0, 1'b0, 0, HEAD_LEFT);
        finish_phase();

        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                tx_idle_pct = 58;
                rx_idle_pct = 6;
            end
            if (p == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0: set_registers(7'd64, 7'd8);
                1: set_registers(7'd5, 7'd8);
                2: set_registers(7'd0, 7'd0);
                3: set_registers(7'd2, 7'd3);
                4: set_registers(7'd127, 7'h7F);
                default: set_registers(7'($urandom_range(64, 2)), 7'($urandom_range(8, 1)));
            endcase
            if (p == 0) begin
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            repeat (16) queue_random_word();
            finish_phase();
        end

        if (error_count == 0 && expected_moves.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
